/* rtl/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, widths, register codes and the arctangent table of the
// angular sector cull core.
// ----------------------------------------------------------------------------
package asc_pkg;

   localparam int COORD_W          = 24;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int SCALE_SH         = 6;
   localparam int VEC_W            = 34;
   localparam int ZACC_W           = 29;
   localparam int ANG_W            = 15;
   localparam int CNT_W            = 32;
   localparam int ATAN_ENTRIES     = 24;
   localparam int ATAN_IDX_W       = 5;
   localparam int RND_SH           = 12;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;

   localparam logic signed [ZACC_W-1:0] PI_24 = 29'sd52707179;

   localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Z   = 2'd1;
   localparam logic [1:0] REG_ANGLE_LOW  = 2'd2;
   localparam logic [1:0] REG_ANGLE_HIGH = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic             inside_res;
      logic [CNT_W-1:0] in_count;
      logic [CNT_W-1:0] out_count;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [ANG_W-1:0]   angle_low;
      logic signed [ANG_W-1:0]   angle_high;
   } cfg_type;

   // atan(2^-i) in units of 2^-24 rad, rounded
   function automatic logic signed [ZACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ZACC_W-1:0] v;
      case (idx)
         5'd0:    v = 29'sd13176795;
         5'd1:    v = 29'sd7778716;
         5'd2:    v = 29'sd4110060;
         5'd3:    v = 29'sd2086331;
         5'd4:    v = 29'sd1047214;
         5'd5:    v = 29'sd524117;
         5'd6:    v = 29'sd262123;
         5'd7:    v = 29'sd131069;
         5'd8:    v = 29'sd65536;
         5'd9:    v = 29'sd32768;
         5'd10:   v = 29'sd16384;
         5'd11:   v = 29'sd8192;
         5'd12:   v = 29'sd4096;
         5'd13:   v = 29'sd2048;
         5'd14:   v = 29'sd1024;
         5'd15:   v = 29'sd512;
         5'd16:   v = 29'sd256;
         5'd17:   v = 29'sd128;
         5'd18:   v = 29'sd64;
         5'd19:   v = 29'sd32;
         5'd20:   v = 29'sd16;
         5'd21:   v = 29'sd8;
         5'd22:   v = 29'sd4;
         5'd23:   v = 29'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/angular_sector_cull_core.sv */
// ----------------------------------------------------------------------------
// angular_sector_cull_core
// Bearing-in-sector test for one point per beat, with inside/outside tallies.
//
// A req beat carries a point (point_x, point_z). The core forms the vector
// from the point to the configured apex, computes its bearing with an
// iterative CORDIC (one shift/add step per cycle), and tests it against the
// sector angle_low..angle_high; a sector with angle_low >= angle_high wraps
// through +-pi. Each rsp beat returns the inside flag and both 32-bit tallies
// after that point. One point is in flight at a time: req_ready is high only
// while the sequencer is idle. A new req is taken only once the previous
// point has left the CORDIC, so the throughput is set by the CORDIC loop.
// The rsp register lets the next req be accepted while a result waits; if
// rsp_ready stays low, a finished result is held in the CORDIC until the
// rsp register frees. Reset clears the state, tallies, valids and config.
// ----------------------------------------------------------------------------
module angular_sector_cull_core #(
   parameter int CORDIC_STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  asc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output asc_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [asc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [asc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [asc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_PUT   = 2'd3;

   asc_pkg::cfg_type                  cfg;
   logic [1:0]                        state_ff, state_in;
   logic signed [asc_pkg::DIFF_W-1:0] dx_ff, dx_in, dz_ff, dz_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   asc_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [asc_pkg::CNT_W-1:0]         in_tally_ff, in_tally_in, out_tally_ff, out_tally_in;
   logic                              cord_start, cord_done;
   logic signed [asc_pkg::ANG_W-1:0]  cord_angle;
   logic                              in_sector, out_free, finish;

   asc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   asc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .y_src (dx_ff),
      .x_src (dz_ff),
      .done  (cord_done),
      .angle (cord_angle)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign cord_start = (state_ff == S_START);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = out_free && (((state_ff == S_WAIT) && cord_done) || (state_ff == S_PUT));

   always_comb begin
      if (cfg.angle_low < cfg.angle_high) begin
         in_sector = (cord_angle >= cfg.angle_low) && (cord_angle <= cfg.angle_high);
      end else begin
         in_sector = (cord_angle > cfg.angle_low) || (cord_angle < cfg.angle_high);
      end
   end

   assign dx_in = {cfg.origin_x[asc_pkg::COORD_W-1], cfg.origin_x}
                - {req_data.point_x[asc_pkg::COORD_W-1], req_data.point_x};
   assign dz_in = {cfg.origin_z[asc_pkg::COORD_W-1], cfg.origin_z}
                - {req_data.point_z[asc_pkg::COORD_W-1], req_data.point_z};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      in_tally_in  = in_tally_ff;
      out_tally_in = out_tally_ff;
      if (finish) begin
         if (in_sector) begin
            in_tally_in = in_tally_ff + 1'b1;
         end else begin
            out_tally_in = out_tally_ff + 1'b1;
         end
         rsp_valid_in           = 1'b1;
         rsp_data_in.inside_res = in_sector;
         rsp_data_in.in_count   = in_tally_in;
         rsp_data_in.out_count  = out_tally_in;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cord_done) begin
               state_in = out_free ? S_IDLE : S_PUT;
            end
         end
         S_PUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         in_tally_ff  <= '0;
         out_tally_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         in_tally_ff  <= in_tally_in;
         out_tally_ff <= out_tally_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_valid && req_ready) begin
         dx_ff <= dx_in;
         dz_ff <= dz_in;
      end
   end

endmodule

/* rtl/asc_csr.sv */
// ----------------------------------------------------------------------------
// asc_csr
// APB-style register file holding the apex position and sector bounds.
// ----------------------------------------------------------------------------
module asc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [asc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [asc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [asc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output asc_pkg::cfg_type                 cfg
);

   asc_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       idx;
   logic             wr_en;

   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            asc_pkg::REG_ORIGIN_X:   cfg_in.origin_x   = csr_pwdata[asc_pkg::COORD_W-1:0];
            asc_pkg::REG_ORIGIN_Z:   cfg_in.origin_z   = csr_pwdata[asc_pkg::COORD_W-1:0];
            asc_pkg::REG_ANGLE_LOW:  cfg_in.angle_low  = csr_pwdata[asc_pkg::ANG_W-1:0];
            asc_pkg::REG_ANGLE_HIGH: cfg_in.angle_high = csr_pwdata[asc_pkg::ANG_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         asc_pkg::REG_ORIGIN_X:
            csr_prdata = {{(asc_pkg::CSR_DATA_W-asc_pkg::COORD_W){cfg_ff.origin_x[asc_pkg::COORD_W-1]}},
                          cfg_ff.origin_x};
         asc_pkg::REG_ORIGIN_Z:
            csr_prdata = {{(asc_pkg::CSR_DATA_W-asc_pkg::COORD_W){cfg_ff.origin_z[asc_pkg::COORD_W-1]}},
                          cfg_ff.origin_z};
         asc_pkg::REG_ANGLE_LOW:
            csr_prdata = {{(asc_pkg::CSR_DATA_W-asc_pkg::ANG_W){cfg_ff.angle_low[asc_pkg::ANG_W-1]}},
                          cfg_ff.angle_low};
         asc_pkg::REG_ANGLE_HIGH:
            csr_prdata = {{(asc_pkg::CSR_DATA_W-asc_pkg::ANG_W){cfg_ff.angle_high[asc_pkg::ANG_W-1]}},
                          cfg_ff.angle_high};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/asc_cordic.sv */
// ----------------------------------------------------------------------------
// asc_cordic
// Iterative vectoring CORDIC: one shift/add step per cycle, giving the
// bearing atan2(y, x) rounded to Q3.12 radians.
// ----------------------------------------------------------------------------
module asc_cordic #(
   parameter int CORDIC_STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [asc_pkg::DIFF_W-1:0] y_src,
   input  logic signed [asc_pkg::DIFF_W-1:0] x_src,
   output logic                              done,
   output logic signed [asc_pkg::ANG_W-1:0]  angle
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int SC_W   = asc_pkg::DIFF_W + asc_pkg::SCALE_SH;

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_ITER  = 2'd1;
   localparam logic [1:0] C_ROUND = 2'd2;

   logic [1:0]                         state_ff, state_in;
   logic [STEP_W-1:0]                  step_ff, step_in;
   logic signed [asc_pkg::VEC_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [asc_pkg::ZACC_W-1:0]  z_ff, z_in;
   logic                               zero_ff, zero_in;
   logic                               done_ff, done_in;
   logic signed [asc_pkg::ANG_W-1:0]   angle_ff, angle_in;

   logic signed [SC_W-1:0]             xs, ys;
   logic signed [asc_pkg::VEC_W-1:0]   xe, ye, x_sh, y_sh;
   logic signed [asc_pkg::ZACC_W-1:0]  atan_v, z_rnd, z_shr;

   assign xs     = {x_src, {asc_pkg::SCALE_SH{1'b0}}};
   assign ys     = {y_src, {asc_pkg::SCALE_SH{1'b0}}};
   assign xe     = {{(asc_pkg::VEC_W-SC_W){xs[SC_W-1]}}, xs};
   assign ye     = {{(asc_pkg::VEC_W-SC_W){ys[SC_W-1]}}, ys};
   assign x_sh   = x_ff >>> step_ff;
   assign y_sh   = y_ff >>> step_ff;
   assign atan_v = asc_pkg::atan_entry(asc_pkg::ATAN_IDX_W'(step_ff));
   assign z_rnd  = z_ff + asc_pkg::ZACC_W'(2048);
   assign z_shr  = z_rnd >>> asc_pkg::RND_SH;

   assign done  = done_ff;
   assign angle = angle_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      angle_in = angle_ff;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               zero_in = (x_src == '0) && (y_src == '0);
               step_in = '0;
               if (x_src[asc_pkg::DIFF_W-1]) begin
                  x_in = -xe;
                  y_in = -ye;
                  z_in = y_src[asc_pkg::DIFF_W-1] ? -asc_pkg::PI_24 : asc_pkg::PI_24;
               end else begin
                  x_in = xe;
                  y_in = ye;
                  z_in = '0;
               end
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (y_ff[asc_pkg::VEC_W-1]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_v;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            angle_in = zero_ff ? '0 : z_shr[asc_pkg::ANG_W-1:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zero_ff  <= zero_in;
      angle_ff <= angle_in;
   end

endmodule
